// ===== design/rlsc_pkg.sv =====
// shared types, widths, register codes and the divider step for the scaler
// used by every module of rational_linear_scaler_clamp_core
package rlsc_pkg;

   localparam int DataWidth     = 32;
   localparam int ProdWidth     = 2 * DataWidth;
   localparam int StepsPerStage = 2;
   localparam int DivStages     = ProdWidth / StepsPerStage;
   localparam int CsrIndexWidth = 3;

   localparam logic signed [ProdWidth-1:0] SatMax =
      {{(DataWidth+1){1'b0}}, {(DataWidth-1){1'b1}}};
   localparam logic signed [ProdWidth-1:0] SatMin =
      {{(DataWidth+1){1'b1}}, {(DataWidth-1){1'b0}}};

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SLOPE_NUM   = 3'd0,
      CSR_SLOPE_DEN   = 3'd1,
      CSR_OFFSET      = 3'd2,
      CSR_LOWER_LIMIT = 3'd3,
      CSR_UPPER_LIMIT = 3'd4,
      CSR_CLAMP_EN    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] slope_num;
      logic        [DataWidth-1:0] den_mag;
      logic                        den_neg;
      logic                        den_zero;
      logic signed [DataWidth-1:0] offset;
      logic signed [DataWidth-1:0] lower;
      logic signed [DataWidth-1:0] upper;
      logic                        clamp_en;
   } cfg_type;

   typedef struct packed {
      logic [ProdWidth-1:0] dq;
      logic [DataWidth-1:0] rem;
      logic                 neg;
   } div_type;

   // restoring division, dividend bits shift out of dq as quotient bits shift in
   function automatic div_type div_step(div_type s, logic [DataWidth-1:0] d);
      div_type          r;
      logic [DataWidth:0] t;
      logic             q;
      r = s;
      for (int i = 0; i < StepsPerStage; i++) begin
         t = {r.rem, r.dq[ProdWidth-1]};
         q = (t >= {1'b0, d});
         if (q) begin
            t = t - {1'b0, d};
         end
         r.rem = t[DataWidth-1:0];
         r.dq  = {r.dq[ProdWidth-2:0], q};
      end
      return r;
   endfunction

endpackage

// ===== design/rlsc_csr.sv =====
// configuration registers of the scaler, written through the csr channel
// depends on rlsc_pkg
module rlsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rlsc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [rlsc_pkg::DataWidth-1:0]      csr_data,
   output rlsc_pkg::cfg_type                   cfg
);

   logic signed [rlsc_pkg::DataWidth-1:0] num_ff, num_in;
   logic signed [rlsc_pkg::DataWidth-1:0] den_ff, den_in;
   logic signed [rlsc_pkg::DataWidth-1:0] offset_ff, offset_in;
   logic signed [rlsc_pkg::DataWidth-1:0] lower_ff, lower_in;
   logic signed [rlsc_pkg::DataWidth-1:0] upper_ff, upper_in;
   logic                                  clamp_ff, clamp_in;

   assign csr_ready = 1'b1;

   always_comb begin
      num_in    = num_ff;
      den_in    = den_ff;
      offset_in = offset_ff;
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      clamp_in  = clamp_ff;
      if (csr_valid) begin
         case (rlsc_pkg::csr_index_type'(csr_index))
            rlsc_pkg::CSR_SLOPE_NUM:   num_in    = csr_data;
            rlsc_pkg::CSR_SLOPE_DEN:   den_in    = csr_data;
            rlsc_pkg::CSR_OFFSET:      offset_in = csr_data;
            rlsc_pkg::CSR_LOWER_LIMIT: lower_in  = csr_data;
            rlsc_pkg::CSR_UPPER_LIMIT: upper_in  = csr_data;
            rlsc_pkg::CSR_CLAMP_EN:    clamp_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff    <= rlsc_pkg::DataWidth'(1);
         den_ff    <= rlsc_pkg::DataWidth'(1);
         offset_ff <= '0;
         lower_ff  <= {1'b1, {(rlsc_pkg::DataWidth-1){1'b0}}};
         upper_ff  <= {1'b0, {(rlsc_pkg::DataWidth-1){1'b1}}};
         clamp_ff  <= 1'b1;
      end else begin
         num_ff    <= num_in;
         den_ff    <= den_in;
         offset_ff <= offset_in;
         lower_ff  <= lower_in;
         upper_ff  <= upper_in;
         clamp_ff  <= clamp_in;
      end
   end

   always_comb begin
      cfg.slope_num = num_ff;
      cfg.den_neg   = den_ff[rlsc_pkg::DataWidth-1];
      cfg.den_mag   = den_ff[rlsc_pkg::DataWidth-1] ? (~den_ff + 1'b1) : den_ff;
      cfg.den_zero  = (den_ff == '0);
      cfg.offset    = offset_ff;
      cfg.lower     = lower_ff;
      cfg.upper     = upper_ff;
      cfg.clamp_en  = clamp_ff;
   end

endmodule

// ===== design/rlsc_mul.sv =====
// multiply stage and magnitude stage feeding the divider
// depends on rlsc_pkg
module rlsc_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic signed [rlsc_pkg::DataWidth-1:0] sample,
   input  rlsc_pkg::cfg_type                     cfg,
   output logic                                  out_valid,
   output rlsc_pkg::div_type                     out_div
);

   logic                                  prod_valid_ff;
   logic signed [rlsc_pkg::ProdWidth-1:0] prod_ff, prod_in;
   logic                                  mag_valid_ff;
   rlsc_pkg::div_type                     mag_ff, mag_in;

   always_comb begin
      prod_in    = rlsc_pkg::ProdWidth'(sample) * rlsc_pkg::ProdWidth'(cfg.slope_num);
      mag_in.dq  = prod_ff[rlsc_pkg::ProdWidth-1] ? -prod_ff : prod_ff;
      mag_in.rem = '0;
      mag_in.neg = prod_ff[rlsc_pkg::ProdWidth-1] ^ cfg.den_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         mag_valid_ff  <= 1'b0;
      end else if (adv) begin
         prod_valid_ff <= in_valid;
         mag_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
      end
   end

   assign out_valid = mag_valid_ff;
   assign out_div   = mag_ff;

endmodule

// ===== design/rlsc_div.sv =====
// pipelined restoring divider, two quotient bits per stage
// depends on rlsc_pkg
module rlsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  rlsc_pkg::div_type                 in_div,
   input  logic [rlsc_pkg::DataWidth-1:0]    divisor,
   output logic                              out_valid,
   output rlsc_pkg::div_type                 out_div
);

   logic              valid_ff [rlsc_pkg::DivStages];
   rlsc_pkg::div_type stage_ff [rlsc_pkg::DivStages];
   rlsc_pkg::div_type stage_in [rlsc_pkg::DivStages];

   always_comb begin
      stage_in[0] = rlsc_pkg::div_step(in_div, divisor);
      for (int s = 1; s < rlsc_pkg::DivStages; s++) begin
         stage_in[s] = rlsc_pkg::div_step(stage_ff[s-1], divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < rlsc_pkg::DivStages; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < rlsc_pkg::DivStages; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < rlsc_pkg::DivStages; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_valid = valid_ff[rlsc_pkg::DivStages-1];
   assign out_div   = stage_ff[rlsc_pkg::DivStages-1];

endmodule

// ===== design/rlsc_post.sv =====
// sign and offset stage, clamp stage and saturating output register
// depends on rlsc_pkg
module rlsc_post (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  rlsc_pkg::div_type                     in_div,
   input  rlsc_pkg::cfg_type                     cfg,
   output logic                                  out_valid,
   output logic signed [rlsc_pkg::DataWidth-1:0] out_value,
   output logic                                  out_error
);

   logic                                  sum_valid_ff;
   logic signed [rlsc_pkg::ProdWidth-1:0] sum_ff, sum_in;
   logic                                  clamp_valid_ff;
   logic signed [rlsc_pkg::ProdWidth-1:0] clamp_ff, clamp_in;
   logic                                  out_valid_ff;
   logic signed [rlsc_pkg::DataWidth-1:0] value_ff, value_in;
   logic                                  error_ff, error_in;
   logic signed [rlsc_pkg::ProdWidth-1:0] quot;
   logic signed [rlsc_pkg::ProdWidth-1:0] upper_ext;
   logic signed [rlsc_pkg::ProdWidth-1:0] lower_ext;

   always_comb begin
      quot      = in_div.neg ? -$signed(in_div.dq) : $signed(in_div.dq);
      sum_in    = quot + rlsc_pkg::ProdWidth'(cfg.offset);
      upper_ext = rlsc_pkg::ProdWidth'(cfg.upper);
      lower_ext = rlsc_pkg::ProdWidth'(cfg.lower);
      clamp_in  = sum_ff;
      if (cfg.clamp_en) begin
         if (sum_ff > upper_ext) begin
            clamp_in = upper_ext;
         end else if (sum_ff < lower_ext) begin
            clamp_in = lower_ext;
         end
      end
      error_in = cfg.den_zero;
      if (cfg.den_zero) begin
         value_in = '0;
      end else if (clamp_ff > rlsc_pkg::SatMax) begin
         value_in = rlsc_pkg::SatMax[rlsc_pkg::DataWidth-1:0];
      end else if (clamp_ff < rlsc_pkg::SatMin) begin
         value_in = rlsc_pkg::SatMin[rlsc_pkg::DataWidth-1:0];
      end else begin
         value_in = clamp_ff[rlsc_pkg::DataWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff   <= 1'b0;
         clamp_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else if (adv) begin
         sum_valid_ff   <= in_valid;
         clamp_valid_ff <= sum_valid_ff;
         out_valid_ff   <= clamp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff   <= sum_in;
         clamp_ff <= clamp_in;
         value_ff <= value_in;
         error_ff <= error_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = value_ff;
   assign out_error = error_ff;

endmodule

// ===== design/rational_linear_scaler_clamp_core.sv =====
// top level of the rational linear scaler with clamp
// depends on rlsc_pkg, rlsc_csr, rlsc_mul, rlsc_div, rlsc_post
//
// usage:
//   req channel carries one signed raw sample per transaction, rsp channel
//   returns one scaled value and a divide error flag per transaction, in order.
//   csr channel writes the slope numerator, slope denominator, offset, lower
//   and upper limits and clamp enable by index; csr_ready is always high and
//   registers should change only while no transaction is in flight.
//   a sample passes from req to rsp through one multiply stage, one magnitude
//   stage, 32 divider stages retiring two quotient bits each, then offset,
//   clamp and saturating output stages.
//   throughput is one transaction per cycle unless an output stall holds it.
//   a zero denominator gives value zero with the error flag set.
//   reset clears all stage valid bits and loads the register defaults
//   (slope 1/1, offset 0, full range limits, clamping on).
//   while rsp_valid is high and rsp_ready low the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated.
module rational_linear_scaler_clamp_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rlsc_pkg::DataWidth-1:0] req_raw_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rlsc_pkg::DataWidth-1:0] rsp_scaled_value,
   output logic                                  rsp_divide_error,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rlsc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rlsc_pkg::DataWidth-1:0]        csr_data
);

   rlsc_pkg::cfg_type cfg;
   logic              adv;
   logic              mul_valid;
   rlsc_pkg::div_type mul_div;
   logic              div_valid;
   rlsc_pkg::div_type div_out;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   rlsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rlsc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .sample    (req_raw_sample),
      .cfg       (cfg),
      .out_valid (mul_valid),
      .out_div   (mul_div)
   );

   rlsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (mul_valid),
      .in_div    (mul_div),
      .divisor   (cfg.den_mag),
      .out_valid (div_valid),
      .out_div   (div_out)
   );

   rlsc_post u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .in_div    (div_out),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_value (rsp_scaled_value),
      .out_error (rsp_divide_error)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |-> rsp_scaled_value == '0)
      else $error("divide error with nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_error && cfg.clamp_en
         && ($signed(cfg.lower) <= $signed(cfg.upper))
      |-> ($signed(rsp_scaled_value) <= $signed(cfg.upper))
         && ($signed(rsp_scaled_value) >= $signed(cfg.lower)))
      else $error("clamped value outside limits");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== bench/tb_rational_linear_scaler_clamp_core.sv =====
// self-checking bench for rational_linear_scaler_clamp_core: directed and random samples,
// csr phases and output stalls, each response checked against an in-bench scaling predictor
// depends on rlsc_pkg and rational_linear_scaler_clamp_core
module tb_rational_linear_scaler_clamp_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LongHoldCycles = 200;
   localparam int DrainCycles    = 80;
   localparam int RandomPhases   = 13;
   localparam int PhaseSamples   = 150;

   localparam logic signed [rlsc_pkg::DataWidth-1:0] WordMin =
      {1'b1, {(rlsc_pkg::DataWidth-1){1'b0}}};
   localparam logic signed [rlsc_pkg::DataWidth-1:0] WordMax =
      {1'b0, {(rlsc_pkg::DataWidth-1){1'b1}}};
   localparam logic [rlsc_pkg::CsrIndexWidth-1:0] CsrSpareLow  = 3'd6;
   localparam logic [rlsc_pkg::CsrIndexWidth-1:0] CsrSpareHigh = 3'd7;

   typedef struct packed {
      logic signed [rlsc_pkg::DataWidth-1:0] value;
      logic                                  div_error;
   } scaled_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic signed [rlsc_pkg::DataWidth-1:0]   req_raw_sample = '0;
   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic signed [rlsc_pkg::DataWidth-1:0]   rsp_scaled_value;
   logic                                    rsp_divide_error;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [rlsc_pkg::CsrIndexWidth-1:0]      csr_index = '0;
   logic [rlsc_pkg::DataWidth-1:0]          csr_data = '0;

   logic signed [rlsc_pkg::DataWidth-1:0]   cfg_num    = 1;
   logic signed [rlsc_pkg::DataWidth-1:0]   cfg_den    = 1;
   logic signed [rlsc_pkg::DataWidth-1:0]   cfg_offset = 0;
   logic signed [rlsc_pkg::DataWidth-1:0]   cfg_lower  = WordMin;
   logic signed [rlsc_pkg::DataWidth-1:0]   cfg_upper  = WordMax;
   logic                                    cfg_clamp  = 1'b1;

   scaled_type pending_scaled[$];
   int         mismatch_count = 0;
   bit         sender_steady = 1'b0;
   bit         sink_steady = 1'b0;
   bit         hold_rsp_request = 1'b0;

   rational_linear_scaler_clamp_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_raw_sample   (req_raw_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_divide_error (rsp_divide_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic scaled_type scale_sample(logic signed [rlsc_pkg::DataWidth-1:0] sample);
      scaled_type r;
      longint     y;
      r.value = '0;
      r.div_error = 1'b0;
      if (cfg_den == 0) begin
         r.div_error = 1'b1;
      end else begin
         y = (longint'(sample) * longint'(cfg_num)) / longint'(cfg_den)
             + longint'(cfg_offset);
         if (cfg_clamp) begin
            if (y > longint'(cfg_upper)) begin
               y = longint'(cfg_upper);
            end else if (y < longint'(cfg_lower)) begin
               y = longint'(cfg_lower);
            end
         end
         if (y > rlsc_pkg::SatMax) begin
            y = rlsc_pkg::SatMax;
         end else if (y < rlsc_pkg::SatMin) begin
            y = rlsc_pkg::SatMin;
         end
         r.value = y[rlsc_pkg::DataWidth-1:0];
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [rlsc_pkg::DataWidth-1:0] pick_word();
      logic signed [rlsc_pkg::DataWidth-1:0] w;
      case ($urandom_range(0, 9))
         0: w = WordMin;
         1: w = WordMax;
         2: w = 0;
         3: w = 1;
         4: w = -1;
         5, 6: w = $signed($urandom_range(0, 2000)) - 1000;
         default: w = $urandom();
      endcase
      return w;
   endfunction

   task automatic send_sample(input logic signed [rlsc_pkg::DataWidth-1:0] sample);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_scaled.push_back(scale_sample(sample));
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_scaled.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [rlsc_pkg::CsrIndexWidth-1:0] index,
                            input logic [rlsc_pkg::DataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         rlsc_pkg::CSR_SLOPE_NUM:   cfg_num    = data;
         rlsc_pkg::CSR_SLOPE_DEN:   cfg_den    = data;
         rlsc_pkg::CSR_OFFSET:      cfg_offset = data;
         rlsc_pkg::CSR_LOWER_LIMIT: cfg_lower  = data;
         rlsc_pkg::CSR_UPPER_LIMIT: cfg_upper  = data;
         rlsc_pkg::CSR_CLAMP_EN:    cfg_clamp  = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [rlsc_pkg::DataWidth-1:0] num,
                                 input logic [rlsc_pkg::DataWidth-1:0] den,
                                 input logic [rlsc_pkg::DataWidth-1:0] ofs,
                                 input logic [rlsc_pkg::DataWidth-1:0] lower,
                                 input logic [rlsc_pkg::DataWidth-1:0] upper,
                                 input logic [rlsc_pkg::DataWidth-1:0] clamp);
      settle_pipeline();
      write_csr(rlsc_pkg::CSR_SLOPE_NUM, num);
      write_csr(rlsc_pkg::CSR_SLOPE_DEN, den);
      write_csr(rlsc_pkg::CSR_OFFSET, ofs);
      write_csr(rlsc_pkg::CSR_LOWER_LIMIT, lower);
      write_csr(rlsc_pkg::CSR_UPPER_LIMIT, upper);
      write_csr(rlsc_pkg::CSR_CLAMP_EN, clamp);
   endtask

   task automatic test_default_settings();
      send_sample(0);
      send_sample(1);
      send_sample(-1);
      send_sample(WordMax);
      send_sample(WordMin);
   endtask

   task automatic test_zero_denominator();
      apply_settings(5, 0, 3, 5, 10, 1);
      send_sample(WordMax);
      send_sample(WordMin);
   endtask

   task automatic test_crossed_limits();
      apply_settings(1, 1, 0, 100, -100, 1);
      send_sample(200);
      send_sample(0);
      send_sample(-200);
   endtask

   task automatic test_output_saturation();
      apply_settings(WordMin, 1, WordMax, WordMin, WordMax, 0);
      send_sample(WordMin);
      send_sample(WordMax);
      apply_settings(WordMin, -1, 0, WordMin, WordMax, 0);
      send_sample(WordMin);
      send_sample(WordMax);
   endtask

   task automatic test_truncation_toward_zero();
      apply_settings(7, -2, -3, WordMin, WordMax, 1);
      send_sample(-3);
      send_sample(3);
   endtask

   task automatic test_spare_register_index();
      settle_pipeline();
      write_csr(CsrSpareLow, '1);
      write_csr(CsrSpareHigh, '0);
      send_sample(12345);
   endtask

   task automatic test_output_stall();
      apply_settings(3, 2, -7, -1000, 1000, 1);
      hold_rsp_request = 1'b1;
      sender_steady = 1'b1;
      repeat (100) send_sample(pick_word());
      sender_steady = 1'b0;
   endtask

   task automatic randomize_settings();
      logic signed [rlsc_pkg::DataWidth-1:0] den;
      logic signed [rlsc_pkg::DataWidth-1:0] a;
      logic signed [rlsc_pkg::DataWidth-1:0] b;
      logic signed [rlsc_pkg::DataWidth-1:0] t;
      case ($urandom_range(0, 7))
         0: den = 0;
         1: den = pick_word();
         default: begin
            den = $urandom_range(1, 64);
            if ($urandom_range(0, 1) == 1) begin
               den = -den;
            end
         end
      endcase
      a = pick_word();
      b = pick_word();
      if (a > b) begin
         t = a;
         a = b;
         b = t;
      end
      case ($urandom_range(0, 3))
         0: begin
            a = WordMin;
            b = WordMax;
         end
         1: begin
            t = a;
            a = b;
            b = t;
         end
         default: ;
      endcase
      apply_settings(pick_word(), den, pick_word(), a, b, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         write_csr(rlsc_pkg::CsrIndexWidth'($urandom_range(CsrSpareLow, CsrSpareHigh)),
                   $urandom());
      end
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < RandomPhases; p++) begin
         randomize_settings();
         for (int i = 0; i < PhaseSamples; i++) begin
            if (i % 50 == 0) begin
               sender_steady = ($urandom_range(0, 3) == 0);
               sink_steady   = ($urandom_range(0, 3) == 0);
            end
            send_sample(pick_word());
         end
      end
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   initial begin : rsp_sink
      int stall;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else begin
            stall = sink_steady ? 0 : pick_gap();
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_scaled
      scaled_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_scaled.size() == 0) begin
            $display("%0t: unexpected transaction value %0d error %0b", $realtime,
                     rsp_scaled_value, rsp_divide_error);
            mismatch_count++;
         end else begin
            want = pending_scaled.pop_front();
            if (rsp_scaled_value !== want.value) begin
               $display("%0t: scaled_value expected %0d actual %0d", $realtime,
                        want.value, rsp_scaled_value);
               mismatch_count++;
            end
            if (rsp_divide_error !== want.div_error) begin
               $display("%0t: divide_error expected %0b actual %0b", $realtime,
                        want.div_error, rsp_divide_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_settings();
      test_zero_denominator();
      test_crossed_limits();
      test_output_saturation();
      test_truncation_toward_zero();
      test_spare_register_index();
      test_output_stall();
      test_random_settings();
      settle_pipeline();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_scaled.size() == 0) begin
         $display("rational_linear_scaler_clamp_core verification clean");
      end else begin
         $display("rational_linear_scaler_clamp_core verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("rational_linear_scaler_clamp_core verification failed");
      $finish;
   end

endmodule
